// ===== rtl/bsp_pkg.sv =====
package bsp_pkg;

	// Parser phase codes.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_UNIT   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Unit codes. The scale is 2^(10 * code).
	localparam logic [2:0] UNIT_NONE = 3'd0;
	localparam logic [2:0] UNIT_K    = 3'd1;
	localparam logic [2:0] UNIT_M    = 3'd2;
	localparam logic [2:0] UNIT_G    = 3'd3;
	localparam logic [2:0] UNIT_T    = 3'd4;

	// Characters of interest.
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_K    = 8'h4B;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_T    = 8'h54;

	localparam int ACC_W = 63;

	typedef struct packed {
		logic [1:0]       phase;
		logic [ACC_W-1:0] accum;
		logic [2:0]       unit;
		logic             bad;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_FIRST,
		accum: '0,
		unit:  UNIT_NONE,
		bad:   1'b0
	};

endpackage

// ===== rtl/bsp_step.sv =====
module bsp_step import bsp_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   ch,
	input  logic         last,
	output parse_state_t nxt,
	output logic [63:0]  bytes
);

	logic             is_digit;
	logic             is_unit;
	logic [2:0]       unit_code;
	logic [ACC_W+3:0] acc_wide;
	logic             acc_ovf;
	logic             fits;
	logic [ACC_W-1:0] scaled;
	logic             ok;
	parse_state_t     upd;

	assign is_digit = ch inside {[CH_ZERO:CH_NINE]};

	// accum * 10 + digit, with four guard bits to spot overflow.
	assign acc_wide = ({4'b0, cur.accum} << 3) + ({4'b0, cur.accum} << 1)
		+ (ACC_W+4)'(ch[3:0]);
	assign acc_ovf = |acc_wide[ACC_W+3:ACC_W];

	always_comb begin
		is_unit   = 1'b1;
		unit_code = UNIT_NONE;
		case (ch)
			CH_K: unit_code = UNIT_K;
			CH_M: unit_code = UNIT_M;
			CH_G: unit_code = UNIT_G;
			CH_T: unit_code = UNIT_T;
			default: is_unit = 1'b0;
		endcase
	end

	always_comb begin
		upd = cur;
		case (cur.phase)
			PH_FIRST: begin
				if (is_digit) begin
					upd.phase = PH_DIGITS;
					if (acc_ovf) upd.bad = 1'b1;
					else upd.accum = acc_wide[ACC_W-1:0];
				end else begin
					upd.bad = 1'b1;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					if (acc_ovf) upd.bad = 1'b1;
					else upd.accum = acc_wide[ACC_W-1:0];
				end else if (ch == CH_B) begin
					upd.phase = PH_DONE;
				end else if (is_unit) begin
					upd.unit  = unit_code;
					upd.phase = PH_UNIT;
				end else begin
					upd.bad = 1'b1;
				end
			end
			PH_UNIT: begin
				if (ch == CH_B) upd.phase = PH_DONE;
				else upd.bad = 1'b1;
			end
			default: upd.bad = 1'b1;
		endcase
		nxt = last ? STATE_RESET : upd;
	end

	// A good string ends on B, which leaves the value untouched, so the
	// result is scaled from the value held before this character.
	always_comb begin
		case (cur.unit)
			UNIT_NONE: begin
				fits   = 1'b1;
				scaled = cur.accum;
			end
			UNIT_K: begin
				fits   = ~|cur.accum[ACC_W-1:ACC_W-10];
				scaled = cur.accum << 10;
			end
			UNIT_M: begin
				fits   = ~|cur.accum[ACC_W-1:ACC_W-20];
				scaled = cur.accum << 20;
			end
			UNIT_G: begin
				fits   = ~|cur.accum[ACC_W-1:ACC_W-30];
				scaled = cur.accum << 30;
			end
			UNIT_T: begin
				fits   = ~|cur.accum[ACC_W-1:ACC_W-40];
				scaled = cur.accum << 40;
			end
			default: begin
				fits   = 1'b0;
				scaled = cur.accum;
			end
		endcase
	end

	assign ok = !cur.bad && (ch == CH_B) && fits
		&& ((cur.phase == PH_DIGITS) || (cur.phase == PH_UNIT));
	assign bytes = ok ? {1'b0, scaled} : '1;

endmodule

// ===== rtl/byte_size_string_parser.sv =====
// Byte size string parser. Characters of a size string such as "512B", "64KB"
// or "3GB" arrive one request at a time on the item channel, with last set on
// the final character. A string must be one or more decimal digits, an
// optional unit letter K, M, G or T (powers of 1024), and then B. Only the
// character flagged as last produces a result: the byte count, or -1 when the
// format is wrong, the decimal value passes 2^63-1, or the scaled value does.
// After that character the parser starts afresh for the next string.
// A request is held in an input register and the parse state and result are
// updated from it as it advances, so a new character can be taken on every
// clock unless a last character waits for the output register. The loop that
// sets the rate is the update of the running value (times ten plus the digit).
// A result waits in an output register; characters that are not last keep
// flowing while it waits, and a last character stalls only until it is taken.
module byte_size_string_parser import bsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [63:0] bytes
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic [63:0]  bytes_nxt;
	logic [63:0]  bytes_q;
	logic         result_valid_q;
	logic         out_free;
	logic         advance;

	// The output register can take a result if it is empty or being emptied.
	assign out_free   = !result_valid_q || result_ready;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	bsp_step u_step (
		.cur   (state_q),
		.ch    (ch_s1),
		.last  (last_s1),
		.nxt   (state_nxt),
		.bytes (bytes_nxt)
	);

	// The parse state is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			bytes_q <= bytes_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign bytes        = bytes_q;

endmodule
